// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted key table
// Command and status codes, the request/response structs passed between the
// stream wrapper and the table engine, and the engine state encoding.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int STS_DEPTH = 64;  // table entries, 2..64 (index fields are 7 bits)
  localparam int KEY_W     = 32;
  localparam int IDX_W     = 7;
  localparam int STAT_W    = 2;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_F_FIRST,
    S_F_LAST,
    S_F_ISSUE,
    S_F_CMP,
    S_I_SHIFT,
    S_R_SHIFT,
    S_DONE
  } sts_state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] lower_index;
    logic [IDX_W-1:0] upper_index;
    logic [KEY_W-1:0] removed_key;
    status_t          status;
  } rsp_t;

endpackage

// ===== src/sts_engine.sv =====
// ----------------------------------------------------------------------------
// sts_engine: table memory and command sequencer
// Holds the keys in a single-port-write / single-port-read synchronous RAM and
// runs find (bisection), insert (shift up) and remove (shift down) on it.
// ----------------------------------------------------------------------------
module sts_engine
  import sts_pkg::*;
#(
  parameter int DEPTH = STS_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic compare_signed,
  input  logic start,
  input  req_t req_in,
  output logic idle,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  sts_state_t       state, state_next;
  req_t             req;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] lo, hi, mid;
  logic             have;
  logic             first;

  logic [KEY_W-1:0] mem [DEPTH];
  logic             mem_re, mem_we;
  logic [AW-1:0]    mem_raddr, mem_waddr;
  logic [KEY_W-1:0] mem_wdata, mem_rdata;

  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_c;
  logic [IDX_W-1:0] cnt_m1;
  logic [IDX_W-1:0] ptr_m1, ptr_p1, ptr_m2;
  logic [KEY_W-1:0] ord_key, ord_ent;
  logic             key_lt_ent;   // key < entry just read
  logic             ent_gt_key;   // entry just read > key
  logic             span_gt1;
  logic             full;

  // Signed keys order as unsigned once the sign bit is flipped
  assign ord_key    = {req.key[KEY_W-1] ^ compare_signed, req.key[KEY_W-2:0]};
  assign ord_ent    = {mem_rdata[KEY_W-1] ^ compare_signed, mem_rdata[KEY_W-2:0]};
  assign key_lt_ent = ord_key < ord_ent;
  assign ent_gt_key = key_lt_ent;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_c    = mid_sum[IDX_W:1];
  assign span_gt1 = (hi - lo) > IDX_W'(1);
  assign cnt_m1   = count - IDX_W'(1);
  assign ptr_m1   = ptr - IDX_W'(1);
  assign ptr_p1   = ptr + IDX_W'(1);
  assign ptr_m2   = ptr - IDX_W'(2);
  assign full     = count == IDX_W'(DEPTH);

  // Key RAM with a registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (req.cmd)
          CMD_FIND:   state_next = (count == '0) ? S_DONE : S_F_FIRST;
          CMD_INSERT: state_next = (req.position > count || full) ? S_DONE : S_I_SHIFT;
          CMD_REMOVE: state_next = (req.position >= count) ? S_DONE : S_R_SHIFT;
          default:    state_next = S_DONE;
        endcase
      end
      S_F_FIRST: state_next = key_lt_ent ? S_DONE : S_F_LAST;
      S_F_LAST:  state_next = key_lt_ent ? S_F_ISSUE : S_DONE;
      S_F_ISSUE: state_next = span_gt1 ? S_F_CMP : S_DONE;
      S_F_CMP:   state_next = S_F_ISSUE;
      S_I_SHIFT: begin
        if (ptr == req.position && !have) state_next = S_DONE;
      end
      S_R_SHIFT: begin
        if (ptr >= count) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    res_valid = 1'b0;
    idle      = 1'b0;
    unique case (state)
      S_IDLE: idle = 1'b1;
      S_DISPATCH: begin
        if (req.cmd == CMD_FIND && count != '0) begin
          mem_re = 1'b1;
        end else if (req.cmd == CMD_REMOVE && req.position < count) begin
          mem_re    = 1'b1;
          mem_raddr = req.position[AW-1:0];
        end
      end
      S_F_FIRST: begin
        mem_re    = !key_lt_ent;
        mem_raddr = cnt_m1[AW-1:0];
      end
      S_F_LAST: ;
      S_F_ISSUE: begin
        mem_re    = span_gt1;
        mem_raddr = mid_c[AW-1:0];
      end
      S_F_CMP: ;
      S_I_SHIFT: begin
        // pending data was read from ptr and lands one slot up
        if (have) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_p1[AW-1:0];
        end
        if (ptr > req.position) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_m1[AW-1:0];
        end else if (!have) begin
          mem_we    = 1'b1;
          mem_waddr = req.position[AW-1:0];
          mem_wdata = req.key;
        end
      end
      S_R_SHIFT: begin
        // data in hand was read from ptr-1 and lands one slot down
        if (!first) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_m2[AW-1:0];
        end
        if (ptr < count) begin
          mem_re    = 1'b1;
          mem_raddr = ptr[AW-1:0];
        end
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_I_SHIFT: begin
          if (ptr == req.position && !have) count <= count + IDX_W'(1);
        end
        S_R_SHIFT: begin
          if (ptr >= count) count <= cnt_m1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          req <= req_in;
          rsp <= '0;
        end
      end
      S_DISPATCH: begin
        ptr   <= (req.cmd == CMD_INSERT) ? count : req.position + IDX_W'(1);
        have  <= 1'b0;
        first <= 1'b1;
        if (req.cmd == CMD_INSERT) begin
          if (req.position > count) rsp.status <= ST_BAD_POS;
          else if (full)            rsp.status <= ST_FULL;
        end else if (req.cmd == CMD_REMOVE && req.position >= count) begin
          rsp.status <= ST_BAD_POS;
        end
      end
      S_F_LAST: begin
        if (!key_lt_ent) begin
          rsp.lower_index <= cnt_m1;
          rsp.upper_index <= count;
        end
        lo <= '0;
        hi <= cnt_m1;
      end
      S_F_ISSUE: begin
        mid <= mid_c;
        if (!span_gt1) begin
          rsp.lower_index <= lo;
          rsp.upper_index <= hi;
        end
      end
      S_F_CMP: begin
        if (ent_gt_key) hi <= mid;
        else            lo <= mid;
      end
      S_I_SHIFT: begin
        if (ptr > req.position) begin
          ptr  <= ptr_m1;
          have <= 1'b1;
        end else begin
          have <= 1'b0;
        end
      end
      S_R_SHIFT: begin
        first <= 1'b0;
        if (first) rsp.removed_key <= mem_rdata;
        if (ptr < count) ptr <= ptr_p1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= IDX_W'(DEPTH))
    else $error("entry count above table depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");

  a_find_pair: assert property (@(posedge clk) disable iff (rst)
    (res_valid && req.cmd == CMD_FIND) |->
      ((rsp.upper_index == rsp.lower_index + IDX_W'(1)) ||
       (rsp.upper_index == '0 && rsp.lower_index == '0)))
    else $error("find result is not an adjacent pair");

  a_count_only_on_edit: assert property (@(posedge clk) disable iff (rst)
    (state != S_I_SHIFT && state != S_R_SHIFT) |=> $stable(count))
    else $error("entry count changed outside insert or remove");
`endif

endmodule

// ===== src/sorted_table_search_insert_remove.sv =====
// ----------------------------------------------------------------------------
// sorted_table_search_insert_remove: sorted key table with find/insert/remove
// Stream front end, compare-mode register and result register around the
// table engine; one command in, one result out.
// ----------------------------------------------------------------------------
// Find checks the first and last entries, then bisects over the registered RAM
//   read; insert and remove shift the entries from the position to the end of
//   the table; rejected or undefined commands go straight to the result.
// Commands: one at a time; the next is taken the cycle after the result moves
//   to the output register.
// Reset: synchronous; clears the entry count, state, compare mode and output
//   valid. Table contents are not cleared (entries are read only after write).
module sorted_table_search_insert_remove
  import sts_pkg::*;
#(
  parameter int DEPTH = STS_DEPTH   // 2..64
) (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,      // [31:0] key, [38:32] position, [39] zero
  input  logic [1:0]  s_tuser,      // [1:0] cmd
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,      // [6:0] lower_index, [13:7] upper_index,
                                    // [45:14] removed_key, [47:46] status
  // compare-mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data      // compare_signed
);

  logic compare_signed;
  logic eng_idle;
  logic eng_res_valid;
  logic eng_res_ready;
  req_t req_in;
  rsp_t eng_rsp;
  rsp_t out_rsp;

  // Register writes must arrive only while idle, which the block leaves to the user; they are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_signed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      compare_signed <= cfg_data;
    end
  end

  // Unpack the command transfer; bit 39 of tdata is padding.
  assign req_in.cmd      = cmd_t'(s_tuser);
  assign req_in.key      = s_tdata[KEY_W-1:0];
  assign req_in.position = s_tdata[KEY_W +: IDX_W];

  // Engine takes a new command whenever it is idle; a finished result has
  // already been moved to the output register by then.
  assign s_tready = eng_idle;

  sts_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .compare_signed (compare_signed),
    .start          (s_tvalid && s_tready),
    .req_in         (req_in),
    .idle           (eng_idle),
    .res_valid      (eng_res_valid),
    .res_ready      (eng_res_ready),
    .rsp            (eng_rsp)
  );

  // Output register: loads when empty or being drained this cycle.
  assign eng_res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_res_ready) begin
      m_tvalid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_rsp <= eng_rsp;
    end
  end

  assign m_tdata = {out_rsp.status, out_rsp.removed_key,
                    out_rsp.upper_index, out_rsp.lower_index};

endmodule

// ===== tb/sorted_table_search_insert_remove_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_insert_remove_tb: self-checking bench for the key table
// Drives find/insert/remove commands over the command stream and keeps a
// mirror of the table that works out each result. Every result transfer is
// checked field by field in order. Compare mode is toggled between phases
// while the block is idle. Both stream sides idle at random, and the result
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sorted_table_search_insert_remove_tb
  import sts_pkg::*;
;

  localparam logic [1:0] CMD_UNDEFINED = 2'd3;  // ignored by the block, gives zeros
  localparam int STALL_LIMIT    = 5000;  // cycles with no transfer at all
  localparam int HOLD_CYCLES    = 400;
  localparam int ITEMS_PER_PHASE = 150;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_wanted;   // written by the main flow only
  bit          hold_done;     // cleared at start, then set by the result side only
  int unsigned hold_left;
  int unsigned stall_cycles;

  // Mirror of the table: works out the result of each command and holds the
  // results still owed by the block, oldest first.
  class key_table_mirror;
    bit [KEY_W-1:0] keys [STS_DEPTH];
    int unsigned    count;
    bit             signed_mode;
    rsp_t           results_due [$];
    int unsigned    mismatches;

    function bit key_less(bit [KEY_W-1:0] a, bit [KEY_W-1:0] b);
      if (signed_mode) return $signed(a) < $signed(b);
      return a < b;
    endfunction

    // insert position that keeps the table ascending (after equal keys)
    function int unsigned sorted_slot(bit [KEY_W-1:0] k);
      for (int unsigned i = 0; i < count; i++)
        if (key_less(k, keys[i])) return i;
      return count;
    endfunction

    // bracketing pair by bisection; runs the same on an unsorted table
    function void locate(bit [KEY_W-1:0] k, output int unsigned lo, output int unsigned hi);
      int unsigned mid;
      lo = 0;
      hi = 0;
      if (count == 0 || key_less(k, keys[0])) return;
      if (!key_less(k, keys[count-1])) begin
        lo = count - 1;
        hi = count;
        return;
      end
      hi = count - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (!key_less(k, keys[lo]) && key_less(k, keys[mid])) hi = mid;
        else lo = mid;
      end
    endfunction

    function void apply_command(bit [1:0] cmd, bit [KEY_W-1:0] k, bit [IDX_W-1:0] pos);
      rsp_t        r;
      int unsigned lo, hi;
      r = '0;
      case (cmd)
        CMD_FIND: begin
          locate(k, lo, hi);
          r.lower_index = lo[IDX_W-1:0];
          r.upper_index = hi[IDX_W-1:0];
        end
        CMD_INSERT: begin
          // position is checked before the full condition
          if (pos > count) r.status = ST_BAD_POS;
          else if (count >= STS_DEPTH) r.status = ST_FULL;
          else begin
            for (int unsigned i = count; i > pos; i--) keys[i] = keys[i-1];
            keys[pos] = k;
            count++;
          end
        end
        CMD_REMOVE: begin
          if (pos >= count) r.status = ST_BAD_POS;
          else begin
            r.removed_key = keys[pos];
            for (int unsigned i = pos; i + 1 < count; i++) keys[i] = keys[i+1];
            count--;
          end
        end
        default: ;  // undefined command: all zero, state unchanged
      endcase
      results_due.push_back(r);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%t ERROR: %s", $realtime, what);
    endfunction

    function void compare_result(logic [47:0] word);
      rsp_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result transfer with none due, data %h", word));
        return;
      end
      want = results_due.pop_front();
      if (word[6:0] !== want.lower_index || word[13:7] !== want.upper_index ||
          word[45:14] !== want.removed_key || word[47:46] !== want.status) begin
        report($sformatf({"result mismatch: lower %0d/%0d upper %0d/%0d ",
                          "removed %h/%h status %0d/%0d (expected/actual)"},
                         want.lower_index, word[6:0], want.upper_index, word[13:7],
                         want.removed_key, word[45:14], want.status, word[47:46]));
      end
    endfunction
  endclass

  key_table_mirror mirror;

  sorted_table_search_insert_remove u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result side: check each transfer, then pick the next ready. A single long
  // hold-off is counted here once the main flow asks for it.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) mirror.compare_result(m_tdata);
    if (hold_wanted && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One command transfer. Valid stays high between back-to-back commands and
  // drops only for an idle gap, so it never gets two assignments in a step.
  task automatic send_command(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
                              input logic [IDX_W-1:0] pos);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pos, k};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    mirror.apply_command(cmd, k, pos);
  endtask

  // Stop offering and wait for every owed result.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (mirror.results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic signed_cmp);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= signed_cmp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.signed_mode = signed_cmp;
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic: inserts keep the table ascending for the
  // current compare mode, finds aim at stored keys and their neighbors. The
  // mix swings between filling the table up to full and draining it.
  task automatic send_random(inout bit growing);
    int unsigned      n, roll;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] pos;
    n = mirror.count;
    if (n == STS_DEPTH && $urandom_range(0, 5) == 0) growing = 1'b0;
    if (n == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
    roll = $urandom_range(0, 99);
    k    = any_key();
    pos  = IDX_W'($urandom_range(0, 127));
    if (roll < 4) begin
      cmd = CMD_UNDEFINED;
    end else if (roll < 26) begin
      cmd = CMD_FIND;
      if (n > 0 && $urandom_range(0, 2) != 0)
        k = mirror.keys[$urandom_range(0, n-1)] + 32'($urandom_range(0, 2)) - 32'd1;
    end else if (roll < (growing ? 86 : 36)) begin
      cmd = CMD_INSERT;
      case ($urandom_range(0, 19))
        0:       ;  // any position, mostly out of range
        1, 2:    pos = IDX_W'($urandom_range(0, n));
        default: pos = IDX_W'(mirror.sorted_slot(k));
      endcase
    end else begin
      cmd = CMD_REMOVE;
      if (n > 0 && $urandom_range(0, 19) != 0) pos = IDX_W'($urandom_range(0, n-1));
    end
    send_command(cmd, k, pos);
  endtask

  initial begin
    bit growing;
    mirror        = new();
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tuser       <= CMD_FIND;
    m_tready      <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    src_idle_pct  <= 18;
    sink_idle_pct <= 47;
    hold_wanted   <= 1'b0;
    hold_done     <= 1'b0;
    hold_left     <= 0;
    stall_cycles  <= 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, unsigned compare
    write_mode(1'b0);
    send_command(CMD_FIND,   32'h0,          7'd0);    // empty table
    send_command(CMD_REMOVE, 32'h0,          7'd0);    // remove from empty
    send_command(CMD_INSERT, 32'h1234_5678,  7'd1);    // position past the end
    send_command(CMD_INSERT, 32'hFFFF_FFFF,  7'd127);  // all position bits set
    send_command(CMD_INSERT, 32'd10,         7'd0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF,  7'd1);
    send_command(CMD_INSERT, 32'h8000_0000,  7'd1);
    send_command(CMD_INSERT, 32'd20,         7'd1);    // 10, 20, 8000_0000, FFFF_FFFF
    send_command(CMD_FIND,   32'd5,          7'd0);    // below the first entry
    send_command(CMD_FIND,   32'hFFFF_FFFF,  7'd0);    // at the last entry
    send_command(CMD_FIND,   32'd20,         7'd0);
    send_command(CMD_FIND,   32'h9000_0000,  7'd0);
    send_command(CMD_UNDEFINED, 32'hFFFF_FFFF, 7'd127);

    // directed, signed compare; the table above is now out of order
    write_mode(1'b1);
    send_command(CMD_FIND,   32'd15,         7'd0);    // unsorted table
    send_command(CMD_REMOVE, 32'h0,          7'd3);    // last entry, nothing moves
    send_command(CMD_REMOVE, 32'h0,          7'd0);
    send_command(CMD_REMOVE, 32'h0,          7'd2);    // at the count
    send_command(CMD_REMOVE, 32'h0,          7'd1);    // leaves 20
    send_command(CMD_INSERT, 32'h8000_0000,  7'd0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF,  7'd1);
    send_command(CMD_INSERT, 32'h7FFF_FFFF,  7'd3);    // min, -1, 20, max
    send_command(CMD_FIND,   32'h0,          7'd0);
    send_command(CMD_FIND,   32'h7FFF_FFFF,  7'd0);
    send_command(CMD_FIND,   32'h8000_0000,  7'd0);

    // random phases: heavier idling on the receiver, then on the sender, then none;
    // the long receiver hold-off lands at the start of the third phase
    growing = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase % 2 == 0);
      src_idle_pct  <= (phase == 0) ? 18 : (phase == 1) ? 47 : 0;
      sink_idle_pct <= (phase == 0) ? 47 : (phase == 1) ? 18 : 0;
      if (phase == 2) hold_wanted <= 1'b1;
      repeat (ITEMS_PER_PHASE) send_random(growing);
    end

    settle();
    repeat (80) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sts_pkg.sv
src/sts_engine.sv
src/sorted_table_search_insert_remove.sv
tb/sorted_table_search_insert_remove_tb.sv
